>>> src/irrc_pkg.sv
// ----------------------------------------------------------------------------
// irrc_pkg
// Shared types and constants of the IPv4 range rule classifier.
// ----------------------------------------------------------------------------
`default_nettype none
package irrc_pkg;

  localparam int MAX_RULES_DEF = 16;
  localparam int TAG_BITS_DEF  = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] PROTO_ANY  = 8'd0;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_UDPL = 8'd136;

  localparam logic [16:0] UDP_HDR_BYTES = 17'd8;
  localparam logic [16:0] TCP_HDR_BYTES = 17'd20;

  typedef enum logic [1:0] {
    KIND_CLASSIFY = 2'd0,
    KIND_ADD      = 2'd1,
    KIND_DELETE   = 2'd2,
    KIND_SET_EN   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // One decoded item between front and back. For a classify, addr_a holds
  // the selected address, port_a the selected port and proto the folded one.
  typedef struct packed {
    kind_t       kind;
    logic        flag;
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    logic [7:0]  proto;
    logic [15:0] port_a;
    logic [15:0] port_b;
    logic [7:0]  tag;
    logic        len_ok;
    logic        port_chk;
  } q_item_t;

endpackage
`default_nettype wire

>>> src/irrc_front.sv
// ----------------------------------------------------------------------------
// irrc_front
// Decodes an incoming item: selects address and port, folds the protocol and
// checks the header length.
// ----------------------------------------------------------------------------
`default_nettype none
module irrc_front (
  input  wire logic [1:0]     kind,
  input  wire logic           flag,
  input  wire logic [31:0]    addr_a,
  input  wire logic [31:0]    addr_b,
  input  wire logic [7:0]     proto_in,
  input  wire logic [15:0]    port_a,
  input  wire logic [15:0]    port_b,
  input  wire logic [3:0]     header_words,
  input  wire logic [15:0]    avail_len,
  input  wire logic [7:0]     rule_tag,
  output irrc_pkg::q_item_t   item
);
  import irrc_pkg::*;

  logic [16:0] hlen;
  logic [16:0] avail;
  logic        is_udp;
  logic        is_tcp;

  always_comb begin
    hlen   = {11'd0, header_words, 2'b00};
    avail  = {1'b0, avail_len};
    is_udp = (proto_in == PROTO_UDP) || (proto_in == PROTO_UDPL);
    is_tcp = (proto_in == PROTO_TCP);

    item          = '0;
    item.kind     = kind_t'(kind);
    item.flag     = flag;
    item.addr_a   = addr_a;
    item.addr_b   = addr_b;
    item.proto    = proto_in;
    item.port_a   = port_a;
    item.port_b   = port_b;
    item.tag      = rule_tag;
    item.len_ok   = 1'b1;
    item.port_chk = 1'b0;

    if (kind_t'(kind) == KIND_CLASSIFY) begin
      item.addr_a   = flag ? addr_b : addr_a;
      item.port_a   = flag ? port_a : port_b;
      item.port_chk = is_udp || is_tcp;
      if (is_udp) begin
        item.proto  = PROTO_UDP;
        item.len_ok = avail >= hlen + UDP_HDR_BYTES;
      end else if (is_tcp) begin
        item.len_ok = avail >= hlen + TCP_HDR_BYTES;
      end else begin
        item.proto  = PROTO_ANY;
        item.port_a = 16'd0;
        item.len_ok = avail >= hlen;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/irrc_queue.sv
// ----------------------------------------------------------------------------
// irrc_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module irrc_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  irrc_pkg::q_item_t       push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    nonempty,
  output irrc_pkg::q_item_t       head
);
  import irrc_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  q_item_t           slots [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   fill;

  assign full     = (fill == CntW'(QUEUE_DEPTH));
  assign nonempty = (fill != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/irrc_back.sv
// ----------------------------------------------------------------------------
// irrc_back
// Rule table and execution: parallel range match, add at front, delete and
// enable change on the first exact match, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module irrc_back #(
  parameter int MAX_RULES = irrc_pkg::MAX_RULES_DEF,
  parameter int TAG_BITS  = irrc_pkg::TAG_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_nonempty,
  input  irrc_pkg::q_item_t   q_head,
  output logic                q_pop,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output logic [1:0]          status,
  output logic [7:0]          match_tag,
  output logic [4:0]          rule_count
);
  import irrc_pkg::*;

  localparam int IdxW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CntW = $clog2(MAX_RULES + 1);

  typedef struct packed {
    logic [31:0]         addr_lo;
    logic [31:0]         addr_hi;
    logic [7:0]          proto;
    logic [15:0]         port_lo;
    logic [15:0]         port_hi;
    logic                en;
    logic [TAG_BITS-1:0] tag;
  } rule_t;

  rule_t                 rules [MAX_RULES];
  logic [CntW-1:0]       count;
  logic [MAX_RULES-1:0]  hit;
  logic [MAX_RULES-1:0]  exact;
  logic                  any_hit;
  logic                  any_exact;
  logic [IdxW-1:0]       hit_idx;
  logic [IdxW-1:0]       ex_idx;
  logic                  tbl_full;
  rule_t                 new_rule;
  logic [TAG_BITS+7:0]   tag_in_ext;
  logic [TAG_BITS+7:0]   tag_out_ext;
  logic [CntW+4:0]       count_ext;
  logic [1:0]            status_next;
  logic [7:0]            tag_next;

  assign q_pop    = q_nonempty && (!rsp_valid || !rsp_stall);
  assign tbl_full = (count == CntW'(MAX_RULES));

  always_comb begin
    tag_in_ext       = {{TAG_BITS{1'b0}}, q_head.tag};
    new_rule.addr_lo = q_head.addr_a;
    new_rule.addr_hi = q_head.addr_b;
    new_rule.proto   = q_head.proto;
    new_rule.port_lo = q_head.port_a;
    new_rule.port_hi = q_head.port_b;
    new_rule.en      = q_head.flag;
    new_rule.tag     = tag_in_ext[TAG_BITS-1:0];
  end

  // Per-entry compare, then a priority pick of the lowest index.
  always_comb begin
    for (int i = 0; i < MAX_RULES; i++) begin
      hit[i] = (CntW'(i) < count) && rules[i].en &&
               (q_head.addr_a >= rules[i].addr_lo) &&
               (q_head.addr_a <= rules[i].addr_hi) &&
               ((rules[i].proto == PROTO_ANY) ||
                ((rules[i].proto == q_head.proto) &&
                 (!q_head.port_chk ||
                  ((q_head.port_a >= rules[i].port_lo) &&
                   (q_head.port_a <= rules[i].port_hi)))));
      exact[i] = (CntW'(i) < count) &&
                 (rules[i].addr_lo == q_head.addr_a) &&
                 (rules[i].addr_hi == q_head.addr_b) &&
                 (rules[i].proto == q_head.proto) &&
                 (rules[i].port_lo == q_head.port_a) &&
                 (rules[i].port_hi == q_head.port_b);
    end
    any_hit   = |hit;
    any_exact = |exact;
    hit_idx   = '0;
    ex_idx    = '0;
    for (int i = MAX_RULES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IdxW'(i);
      end
      if (exact[i]) begin
        ex_idx = IdxW'(i);
      end
    end
    tag_out_ext = {8'd0, rules[hit_idx].tag};
  end

  always_comb begin
    status_next = ST_NOMATCH;
    tag_next    = 8'd0;
    case (q_head.kind)
      KIND_CLASSIFY: begin
        if (q_head.len_ok && any_hit) begin
          status_next = ST_OK;
          tag_next    = tag_out_ext[7:0];
        end
      end
      KIND_ADD: begin
        status_next = tbl_full ? ST_FULL : ST_OK;
      end
      KIND_DELETE, KIND_SET_EN: begin
        status_next = any_exact ? ST_OK : ST_NOMATCH;
      end
      default: begin
        status_next = ST_NOMATCH;
      end
    endcase
  end

  assign count_ext  = {5'd0, count};
  assign rule_count = count_ext[4:0];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status    <= status_next;
      match_tag <= tag_next;
      case (q_head.kind)
        KIND_ADD: begin
          if (!tbl_full) begin
            for (int i = MAX_RULES - 1; i > 0; i--) begin
              rules[i] <= rules[i-1];
            end
            rules[0] <= new_rule;
          end
        end
        KIND_DELETE: begin
          if (any_exact) begin
            for (int i = 0; i < MAX_RULES - 1; i++) begin
              if (IdxW'(i) >= ex_idx) begin
                rules[i] <= rules[i+1];
              end
            end
          end
        end
        KIND_SET_EN: begin
          if (any_exact) begin
            rules[ex_idx].en <= q_head.flag;
          end
        end
        default: begin
        end
      endcase
    end
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        rsp_valid <= 1'b1;
        if (q_head.kind == KIND_ADD && !tbl_full) begin
          count <= count + 1'b1;
        end else if (q_head.kind == KIND_DELETE && any_exact) begin
          count <= count - 1'b1;
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/ipv4_range_rule_classifier_top.sv
// ----------------------------------------------------------------------------
// ipv4_range_rule_classifier_top
// IPv4 range rule classifier: priority-ordered flow rule table with classify,
// add, delete and enable-change operations.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries one beat per operation:
//   kind selects classify, add, delete or set-enable; the other fields carry
//   header fields or the rule. A beat is taken when req_valid is high and
//   req_stall is low.
//   Response channel (rsp_valid / rsp_stall) returns exactly one beat per
//   request, in order: status, match_tag and the rule count after the op.
//   A request beat is decoded by the front and written into a two-entry queue
//   when it is accepted; the back pops the entry from the queue, compares it
//   against all rules in parallel and registers the result in the response
//   register, which offers it as the response beat.
//   Throughput is one beat per cycle while the receiver keeps rsp_stall low.
//   When the receiver stalls, the response register holds, the back stops
//   popping, the queue fills and then req_stall rises.
//   Reset empties the rule table (count zero), the queue and the response
//   register; rule storage itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module ipv4_range_rule_classifier_top #(
  parameter int MAX_RULES = irrc_pkg::MAX_RULES_DEF,
  parameter int TAG_BITS  = irrc_pkg::TAG_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  kind,
  input  wire logic        flag,
  input  wire logic [31:0] addr_a,
  input  wire logic [31:0] addr_b,
  input  wire logic [7:0]  proto_in,
  input  wire logic [15:0] port_a,
  input  wire logic [15:0] port_b,
  input  wire logic [3:0]  header_words,
  input  wire logic [15:0] avail_len,
  input  wire logic [7:0]  rule_tag,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [1:0]       status,
  output logic [7:0]       match_tag,
  output logic [4:0]       rule_count
);
  import irrc_pkg::*;

  q_item_t dec_item;
  q_item_t q_head;
  logic    q_full;
  logic    q_nonempty;
  logic    q_pop;
  logic    q_push;

  // Front: decode the beat; take it whenever the queue has room.
  irrc_front u_front (
    .kind         (kind),
    .flag         (flag),
    .addr_a       (addr_a),
    .addr_b       (addr_b),
    .proto_in     (proto_in),
    .port_a       (port_a),
    .port_b       (port_b),
    .header_words (header_words),
    .avail_len    (avail_len),
    .rule_tag     (rule_tag),
    .item         (dec_item)
  );

  assign req_stall = q_full;
  assign q_push    = req_valid && !q_full;

  // Queue: decouple front from back so each side stalls on its own.
  irrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (dec_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  // Back: execute against the rule table and register the response.
  irrc_back #(
    .MAX_RULES (MAX_RULES),
    .TAG_BITS  (TAG_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .match_tag  (match_tag),
    .rule_count (rule_count)
  );

  // A nonzero tag only comes with a successful classify.
  a_tag_ok : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (match_tag != 8'd0) |-> (status == ST_OK))
    else $error("match_tag nonzero without status ok");

  // Table full is reported only when the table really is full.
  a_full_cnt : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> (rule_count == 5'(MAX_RULES)))
    else $error("table full reported with room left");

  // A stalled response holds its count.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rule_count))
    else $error("stalled response changed");

  // The queue only pops when an entry is there.
  a_pop : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_nonempty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire
